@@ hw/rtl/pbf_pkg.sv @@
`default_nettype none
package pbf_pkg;

  typedef enum logic [2:0] {
    FMT_PCM8    = 3'd0,
    FMT_PCM16   = 3'd1,
    FMT_PCM24   = 3'd2,
    FMT_PCM32   = 3'd3,
    FMT_FLOAT32 = 3'd4
  } sample_format_t;

  typedef enum logic [0:0] {
    REG_SAMPLE_FORMAT = 1'd0,
    REG_CHANNEL_COUNT = 1'd1
  } reg_index_t;

  localparam logic [2:0]  FORMAT_RESET   = 3'd1;
  localparam logic [15:0] CHANNELS_RESET = 16'd2;

  // Exponent bias less the scale of each integer format.
  localparam logic [7:0] EXP_PCM8  = 8'd120;
  localparam logic [7:0] EXP_PCM16 = 8'd112;
  localparam logic [7:0] EXP_PCM24 = 8'd104;
  localparam logic [7:0] EXP_PCM32 = 8'd96;

endpackage
`default_nettype wire

@@ hw/rtl/pcm_bytes_to_float32.sv @@
// Channel   Direction  Signals
// config    in         cfg_we, cfg_index, cfg_data
// input     in         in_valid / in_ready, data_byte
// result    out        out_valid / out_ready, sample_bits, channel_index, frame_end
//
// One byte is taken per cycle unless a result is held back; results are registered.
// The conversion sits between the gathering registers and the result register.
// The result register frees itself when taken, so only a held result stalls input.
// Synchronous reset restores the register defaults and empties the result stage.
`default_nettype none
module pcm_bytes_to_float32 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      sample_bits,
  output logic [15:0]      channel_index,
  output logic             frame_end
);
  import pbf_pkg::*;

  logic [2:0]  sample_format;
  logic [15:0] channel_count;
  logic [23:0] gathered_bytes;
  logic [1:0]  byte_slot;
  logic [15:0] channel_counter;

  logic        accept;
  logic        fmt_ok;
  logic [1:0]  last;
  logic        complete;
  logic [31:0] word;
  logic [31:0] conv;
  logic        neg;
  logic [31:0] mag;
  logic [4:0]  top;
  logic [7:0]  exp_base;
  logic [24:0] mant;
  logic [31:0] shifted;
  logic [7:0]  rem_bits;
  logic        round_up;
  logic [16:0] ch_inc;
  logic        end_now;

  // The result register can be refilled in the cycle that it is emptied.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign fmt_ok   = sample_format <= FMT_FLOAT32;

  always_comb begin
    unique case (sample_format)
      FMT_PCM8:  last = 2'd0;
      FMT_PCM16: last = 2'd1;
      FMT_PCM24: last = 2'd2;
      default:   last = 2'd3;
    endcase
  end
  assign complete = fmt_ok && (byte_slot >= last);

  always_comb begin
    unique case (last)
      2'd0:    word = {24'd0, data_byte};
      2'd1:    word = {16'd0, data_byte, gathered_bytes[7:0]};
      2'd2:    word = {8'd0, data_byte, gathered_bytes[15:0]};
      default: word = {data_byte, gathered_bytes};
    endcase
  end

  // Sign and magnitude of the integer sample.
  always_comb begin
    unique case (sample_format)
      FMT_PCM8: begin
        neg = !word[7];
        mag = neg ? (32'd128 - word) : (word - 32'd128);
        exp_base = EXP_PCM8;
      end
      FMT_PCM16: begin
        neg = word[15];
        mag = neg ? (32'h10000 - word) : word;
        exp_base = EXP_PCM16;
      end
      FMT_PCM24: begin
        neg = word[23];
        mag = neg ? (32'h1000000 - word) : word;
        exp_base = EXP_PCM24;
      end
      default: begin
        neg = word[31];
        mag = neg ? (32'd0 - word) : word;
        exp_base = EXP_PCM32;
      end
    endcase
  end

  // Leading one search over the magnitude.
  always_comb begin
    top = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) top = 5'(i);
    end
  end

  // Normalise to 24 bits; only magnitudes above 2^24 lose bits.
  always_comb begin
    shifted  = '0;
    rem_bits = '0;
    round_up = 1'b0;
    if (top <= 5'd23) begin
      mant = {1'b0, 24'(mag << (5'd23 - top))};
    end else begin
      shifted  = mag >> (top - 5'd23);
      rem_bits = 8'(mag << (5'd8 - (top - 5'd23)));
      round_up = rem_bits[7] && ((rem_bits[6:0] != 7'd0) || shifted[0]);
      mant     = 25'(shifted) + 25'(round_up);
    end
  end

  always_comb begin
    logic [7:0] e;
    e = exp_base + 8'(top) + 8'(mant[24]);
    if (sample_format == FMT_FLOAT32) begin
      conv = word;
    end else if (mag == 32'd0) begin
      conv = 32'd0;
    end else if (mant[24]) begin
      conv = {neg, e, mant[23:1]};
    end else begin
      conv = {neg, e, mant[22:0]};
    end
  end

  assign ch_inc  = {1'b0, channel_counter} + 17'd1;
  assign end_now = ch_inc >= {1'b0, channel_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format   <= FORMAT_RESET;
      channel_count   <= CHANNELS_RESET;
      gathered_bytes  <= '0;
      byte_slot       <= '0;
      channel_counter <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SAMPLE_FORMAT: sample_format <= cfg_data[2:0];
          default:           channel_count <= cfg_data;
        endcase
      end
      if (out_ready && !(accept && complete)) out_valid <= 1'b0;
      if (accept && fmt_ok) begin
        if (!complete) begin
          unique case (byte_slot)
            2'd0:    gathered_bytes[7:0]   <= data_byte;
            2'd1:    gathered_bytes[15:8]  <= data_byte;
            default: gathered_bytes[23:16] <= data_byte;
          endcase
          byte_slot <= byte_slot + 2'd1;
        end else begin
          gathered_bytes  <= '0;
          byte_slot       <= '0;
          channel_counter <= end_now ? 16'd0 : ch_inc[15:0];
          out_valid       <= 1'b1;
          sample_bits     <= conv;
          channel_index   <= channel_counter;
          frame_end       <= end_now;
        end
      end
    end
  end

  // A result held back by the consumer keeps its values.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_bits) && $stable(channel_index))
    else $error("result changed while stalled");

  // A result that ends a frame appears with the channel counter wrapped to zero.
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end && $rose(out_valid) |-> channel_counter == 16'd0)
    else $error("counter not wrapped at frame end");

  // A byte that does not complete a sample moves the byte slot off zero.
  a_slot: assert property (@(posedge clk) disable iff (rst)
    accept && fmt_ok && !complete |=> byte_slot != 2'd0)
    else $error("byte slot did not advance");

endmodule
`default_nettype wire

@@ bench/pcm_bytes_to_float32_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module pcm_bytes_to_float32_tb;
  import pbf_pkg::*;

  // A converted sample as the block reports it.
  typedef struct packed {
    logic [31:0] bits;
    logic [15:0] chan;
    logic        last;
  } sample_t;

  // A queued byte.  When is_cfg is set the entry is instead a register write,
  // which the driver only performs once the block has drained.
  typedef struct {
    bit          is_cfg;
    reg_index_t  idx;
    logic [15:0] val;
    logic [7:0]  data;
  } pending_t;

  localparam int LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  reg_index_t  cfg_index = REG_SAMPLE_FORMAT;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] sample_bits;
  logic [15:0] channel_index;
  logic        frame_end;

  pcm_bytes_to_float32 uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready, .data_byte,
    .out_valid, .out_ready, .sample_bits, .channel_index, .frame_end
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state, a private copy of the block's registers.
  logic [2:0]  p_fmt;
  logic [15:0] p_chans;
  logic [23:0] p_gather;
  logic [1:0]  p_slot;
  logic [15:0] p_chan;

  pending_t pending_q[$];
  sample_t  expected_samples[$];
  int       errors = 0;
  int       samples_seen = 0;
  int       cycles = 0;
  int       send_idle = 12;
  int       recv_idle = 51;
  int       hold_off = 0;
  bit       stim_done = 0;

  // Rounds (neg ? -mag : mag) / 2^scale into single precision, ties to even.
  function automatic logic [31:0] to_single(bit neg, logic [31:0] mag, int scale);
    int top;
    int sh;
    logic [32:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    logic [7:0]  expo;
    top = 0;
    if (mag == 0) return 32'h0;
    for (int i = 31; i >= 0; i--) if (mag[i]) begin top = i; break; end
    if (top <= 23) begin
      mant = {1'b0, mag} << (23 - top);
    end else begin
      sh = top - 23;
      rem = mag & ((32'h1 << sh) - 1);
      half = 32'h1 << (sh - 1);
      mant = {1'b0, mag >> sh};
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == 33'h1000000) begin
        mant = mant >> 1;
        top++;
      end
    end
    expo = 8'(top + 127 - scale);
    return {neg, expo, mant[22:0]};
  endfunction

  function automatic logic [31:0] convert_word(logic [2:0] fmt, logic [31:0] w);
    case (fmt)
      FMT_PCM8:  return (w >= 128) ? to_single(0, w - 128, 7) : to_single(1, 128 - w, 7);
      FMT_PCM16: return w[15] ? to_single(1, 32'h10000 - w, 15) : to_single(0, w, 15);
      FMT_PCM24: return w[23] ? to_single(1, 32'h1000000 - w, 23) : to_single(0, w, 23);
      FMT_PCM32: return w[31] ? to_single(1, 32'h0 - w, 31) : to_single(0, w, 31);
      default:   return w;
    endcase
  endfunction

  // Advances the predictor by one accepted byte and queues any sample it completes.
  task automatic predict_byte(logic [7:0] b);
    int last;
    logic [31:0] mask;
    logic [31:0] word;
    sample_t s;
    if (p_fmt > FMT_FLOAT32) return;
    case (p_fmt)
      FMT_PCM8:  last = 0;
      FMT_PCM16: last = 1;
      FMT_PCM24: last = 2;
      default:   last = 3;
    endcase
    if (p_slot < last) begin
      p_gather = p_gather | (24'(b) << (8 * p_slot));
      p_slot = p_slot + 2'd1;
      return;
    end
    mask = (last == 0) ? 32'h0 : (last == 1) ? 32'hFF : (last == 2) ? 32'hFFFF : 32'hFFFFFF;
    word = ({8'h0, p_gather} & mask) | (32'(b) << (8 * last));
    p_gather = '0;
    p_slot = '0;
    s.bits = convert_word(p_fmt, word);
    s.chan = p_chan;
    s.last = (32'(p_chan) + 1) >= 32'(p_chans);
    p_chan = s.last ? 16'h0 : p_chan + 16'd1;
    expected_samples.push_back(s);
  endtask

  task automatic push_byte(logic [7:0] b);
    pending_t p;
    p.is_cfg = 0;
    p.idx = REG_SAMPLE_FORMAT;
    p.val = '0;
    p.data = b;
    pending_q.push_back(p);
  endtask

  task automatic push_cfg(reg_index_t idx, logic [15:0] val);
    pending_t p;
    p.is_cfg = 1;
    p.idx = idx;
    p.val = val;
    p.data = '0;
    pending_q.push_back(p);
  endtask

  // Random bytes, not aligned to whole samples; about three in ten are
  // the extreme bytes 00, FF or 80 so that full scale values show up often.
  task automatic push_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      push_byte(r == 0 ? 8'h00 : r == 1 ? 8'hFF : r == 2 ? 8'h80 : 8'($urandom));
    end
  endtask

  // Driver.  A register write waits until the block is idle: no byte in
  // flight and no sample outstanding, as counted by quiet.
  int quiet = 0;
  always @(posedge clk) begin
    bit cfg_go;
    cfg_go = 1'b0;
    if (!rst) begin
      quiet = (expected_samples.size() == 0 && !in_valid) ? quiet + 1 : 0;
      if (in_valid && in_ready) begin
        predict_byte(data_byte);
        void'(pending_q.pop_front());
      end
      if (!(in_valid && in_ready) && in_valid) begin
        // Holding the current byte until it is taken.
      end else if (pending_q.size() > 0 && pending_q[0].is_cfg) begin
        in_valid <= 1'b0;
        if (quiet >= 3) begin
          cfg_go = 1'b1;
          cfg_index <= pending_q[0].idx;
          cfg_data <= pending_q[0].val;
          if (pending_q[0].idx == REG_SAMPLE_FORMAT) p_fmt = pending_q[0].val[2:0];
          else p_chans = pending_q[0].val;
          void'(pending_q.pop_front());
          quiet = 0;
        end
      end else if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        in_valid <= 1'b1;
        data_byte <= pending_q[0].data;
      end else begin
        in_valid <= 1'b0;
      end
    end
    cfg_we <= cfg_go;
  end

  // Monitor, comparing each taken sample with the oldest prediction.
  always @(posedge clk) begin
    sample_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        samples_seen++;
        if (expected_samples.size() == 0) begin
          $error("unexpected sample bits=%h chan=%0d end=%0b",
                 sample_bits, channel_index, frame_end);
          errors++;
        end else begin
          e = expected_samples.pop_front();
          if (sample_bits !== e.bits) begin
            $error("sample_bits expected %h actual %h", e.bits, sample_bits);
            errors++;
          end
          if (channel_index !== e.chan) begin
            $error("channel_index expected %0d actual %0d", e.chan, channel_index);
            errors++;
          end
          if (frame_end !== e.last) begin
            $error("frame_end expected %0b actual %0b", e.last, frame_end);
            errors++;
          end
        end
      end
      // A long hold-off is counted here so the input side backs up.
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int drain;
    p_fmt = FORMAT_RESET;
    p_chans = CHANNELS_RESET;
    p_gather = '0;
    p_slot = '0;
    p_chan = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset format is 16-bit stereo.  Full scale, zero, -1 and
    // the smallest step in the 16-bit and 8-bit formats.
    push_byte(8'h00); push_byte(8'h00);
    push_byte(8'hFF); push_byte(8'h7F);
    push_byte(8'h00); push_byte(8'h80);
    push_byte(8'hFF); push_byte(8'hFF);
    push_cfg(REG_SAMPLE_FORMAT, FMT_PCM8);
    push_cfg(REG_CHANNEL_COUNT, 16'd1);
    push_byte(8'h00); push_byte(8'h80); push_byte(8'hFF); push_byte(8'h7F);
    push_cfg(REG_SAMPLE_FORMAT, FMT_PCM24);
    push_cfg(REG_CHANNEL_COUNT, 16'd0);   // a count of zero behaves as one
    push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h7F);
    push_byte(8'h00); push_byte(8'h00); push_byte(8'h80);
    push_cfg(REG_SAMPLE_FORMAT, FMT_PCM32);
    push_cfg(REG_CHANNEL_COUNT, 16'hFFFF);
    // Rounding: 0x7FFFFFFF rounds up to 1.0 and 0x80000001 rounds to -1.0.
    push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h7F);
    push_byte(8'h01); push_byte(8'h00); push_byte(8'h00); push_byte(8'h80);
    push_cfg(REG_SAMPLE_FORMAT, FMT_FLOAT32);
    push_byte(8'h01); push_byte(8'h02); push_byte(8'h03); push_byte(8'hC4);
    // An unused format code swallows bytes without a trace.
    push_cfg(REG_SAMPLE_FORMAT, 3'd7);
    push_byte(8'hAA); push_byte(8'h55);

    // Random phases over formats and channel counts; within a phase the
    // predictor follows any partial sample or counter past the count.
    // The idling pattern changes only once the earlier phases have been sent.
    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 8) begin
        wait (pending_q.size() == 0);
        send_idle = 51;
        recv_idle = 12;
      end
      if (ph == 16) begin
        wait (pending_q.size() == 0);
        send_idle = 0;
        recv_idle = 0;
      end
      if (ph == 18) hold_off = 0;
      push_cfg(REG_SAMPLE_FORMAT, (ph % 9 == 8) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4)));
      case ($urandom_range(0, 4))
        0:       push_cfg(REG_CHANNEL_COUNT, 16'd1);
        1:       push_cfg(REG_CHANNEL_COUNT, 16'hFFFF);
        2:       push_cfg(REG_CHANNEL_COUNT, 16'($urandom));
        default: push_cfg(REG_CHANNEL_COUNT, 16'($urandom_range(0, 8)));
      endcase
      push_random(75);
    end

    // Wait until the phases are under way, then stall the receiver for a
    // long stretch while bytes keep coming.
    wait (send_idle == 0);
    hold_off = 300;

    wait (pending_q.size() == 0);
    stim_done = 1;
    drain = 0;
    while ((expected_samples.size() != 0 || in_valid) && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    $display("Covered %0d samples across all formats, channel counts and idling phases.",
             samples_seen);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
